### design/lcs_pkg.sv
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared sizes, function codes and memory request types for the longest
// common subsequence block.
// ---------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_LEN = 64;
  localparam int DIM     = MAX_LEN + 1;
  localparam int CELLS   = DIM * DIM;

  localparam int LEN_W   = 7;   // fixed width of the length field
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int SCORE_W = 7;
  localparam int SYM_W   = 8;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SYM_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } byte_req_t;

  typedef struct packed {
    logic               we;
    logic [CELL_W-1:0]  waddr;
    logic [SCORE_W-1:0] wdata;
    logic               re;
    logic [CELL_W-1:0]  raddr;
  } score_req_t;

endpackage

### design/lcs_length_and_traceback.sv
// ---------------------------------------------------------------------------
// lcs_length_and_traceback
// Loads two byte strings, fills the LCS score table in memory, traces back
// from the corner and streams the common subsequence first to last.
// ---------------------------------------------------------------------------
//  channel | ports                                        | beat
//  in      | in_valid, in_stall, in_func, in_symbol       | load or run
//  out     | out_valid, out_stall, out_lcs_length,        | one symbol or none
//          | out_sub_char, out_char_valid, out_truncated, |
//          | out_last                                     |
//
// a load or ignored beat is taken only in idle; a run fills the table cell by
// cell (one score port read and write per cell), then traces back step by step
// (at most len_a+len_b steps), then streams one result beat at a time.
// in_stall is high from a run beat until its last result beat is taken.
// reset clears lengths, the overflow flag and the sequencer; no memory clear.
// out_stall only holds the current result, the payload stays put meanwhile.
// ---------------------------------------------------------------------------
module lcs_length_and_traceback (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [lcs_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcs_pkg::LEN_W-1:0]     out_lcs_length,
  output logic [lcs_pkg::SYM_W-1:0]     out_sub_char,
  output logic                          out_char_valid,
  output logic                          out_truncated,
  output logic                          out_last
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL_RD, ST_FILL_WR, ST_TR_HERE, ST_TR_UP, ST_TR_LEFT,
    ST_TR_DEC, ST_EMIT_RD, ST_EMIT_OUT
  } state_t;

  state_t              state_r;
  logic [LEN_W-1:0]    len_a_r, len_b_r;
  logic                overflow_r;
  logic [LEN_W-1:0]    i_r, j_r, n_r, k_r;
  logic [SCORE_W-1:0]  left_r, diag_r, here_r, up_r, len_r;
  logic                out_valid_r, char_valid_r, last_r;

  byte_req_t           sa_req, sb_req, tb_req;
  score_req_t          sc_req;
  logic [SYM_W-1:0]    sa_rdata, sb_rdata, tb_rdata;
  logic [SCORE_W-1:0]  sc_rdata;

  logic                in_acc;
  logic [LEN_W-1:0]    i_dec, j_dec;
  logic [SCORE_W-1:0]  up_val, diag_val, fill_val, tr_left;
  logic                take_up, take_left, take_diag;
  logic [LEN_W-1:0]    ni, nj, n_next;

  function automatic logic [CELL_W-1:0] cell_addr(logic [LEN_W-1:0] row,
                                                  logic [LEN_W-1:0] col);
    return CELL_W'(row) * CELL_W'(DIM) + CELL_W'(col);
  endfunction

  assign in_acc = in_valid && !in_stall;
  assign i_dec  = i_r - LEN_W'(1);
  assign j_dec  = j_r - LEN_W'(1);

  // fill: up comes from memory, diagonal is the previous up, left is the last write
  assign up_val   = (i_r == LEN_W'(1)) ? '0 : sc_rdata;
  assign diag_val = (j_r == LEN_W'(1)) ? '0 : diag_r;
  assign fill_val = (sa_rdata == sb_rdata) ? diag_val + SCORE_W'(1)
                  : ((up_val > left_r) ? up_val : left_r);

  // traceback decision
  assign tr_left   = (j_r == LEN_W'(1)) ? '0 : sc_rdata;
  assign take_up   = (here_r == up_r);
  assign take_left = !take_up && (here_r == tr_left);
  assign take_diag = !take_up && !take_left;
  assign ni        = (take_up || take_diag) ? i_dec : i_r;
  assign nj        = (take_left || take_diag) ? j_dec : j_r;
  assign n_next    = n_r + LEN_W'(take_diag);

  always_comb begin
    sa_req       = '0;
    sa_req.we    = in_acc && (in_func == FUNC_LOAD_A) && (len_a_r < LEN_W'(MAX_LEN));
    sa_req.waddr = IDX_W'(len_a_r);
    sa_req.wdata = in_symbol;
    sa_req.re    = (state_r == ST_FILL_RD) || (state_r == ST_TR_HERE);
    sa_req.raddr = IDX_W'(i_dec);

    sb_req       = '0;
    sb_req.we    = in_acc && (in_func == FUNC_LOAD_B) && (len_b_r < LEN_W'(MAX_LEN));
    sb_req.waddr = IDX_W'(len_b_r);
    sb_req.wdata = in_symbol;
    sb_req.re    = (state_r == ST_FILL_RD);
    sb_req.raddr = IDX_W'(j_dec);

    tb_req       = '0;
    tb_req.we    = (state_r == ST_TR_DEC) && take_diag;
    tb_req.waddr = IDX_W'(n_r);
    tb_req.wdata = sa_rdata;
    tb_req.re    = (state_r == ST_EMIT_RD);
    tb_req.raddr = IDX_W'(n_r - LEN_W'(1) - k_r);

    sc_req       = '0;
    sc_req.we    = (state_r == ST_FILL_WR);
    sc_req.waddr = cell_addr(i_r, j_r);
    sc_req.wdata = fill_val;
    unique case (state_r)
      ST_FILL_RD: begin
        sc_req.re    = 1'b1;
        sc_req.raddr = cell_addr(i_dec, j_r);
      end
      ST_TR_HERE: begin
        sc_req.re    = 1'b1;
        sc_req.raddr = cell_addr(i_r, j_r);
      end
      ST_TR_UP: begin
        sc_req.re    = 1'b1;
        sc_req.raddr = cell_addr(i_dec, j_r);
      end
      ST_TR_LEFT: begin
        sc_req.re    = 1'b1;
        sc_req.raddr = cell_addr(i_r, j_dec);
      end
      default: begin
        sc_req.re    = 1'b0;
        sc_req.raddr = '0;
      end
    endcase
  end

  lcs_byte_ram u_str_a (.clk(clk), .req(sa_req), .rdata(sa_rdata));
  lcs_byte_ram u_str_b (.clk(clk), .req(sb_req), .rdata(sb_rdata));
  lcs_byte_ram u_trace (.clk(clk), .req(tb_req), .rdata(tb_rdata));
  lcs_score_ram u_score (.clk(clk), .req(sc_req), .rdata(sc_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_func)
              FUNC_LOAD_A: begin
                if (len_a_r < LEN_W'(MAX_LEN)) len_a_r <= len_a_r + LEN_W'(1);
                else overflow_r <= 1'b1;
              end
              FUNC_LOAD_B: begin
                if (len_b_r < LEN_W'(MAX_LEN)) len_b_r <= len_b_r + LEN_W'(1);
                else overflow_r <= 1'b1;
              end
              FUNC_RUN: begin
                i_r    <= LEN_W'(1);
                j_r    <= LEN_W'(1);
                n_r    <= '0;
                k_r    <= '0;
                len_r  <= '0;
                left_r <= '0;
                diag_r <= '0;
                if (len_a_r == '0 || len_b_r == '0) begin
                  // empty subsequence beat
                  out_valid_r  <= 1'b1;
                  char_valid_r <= 1'b0;
                  last_r       <= 1'b1;
                  state_r      <= ST_EMIT_OUT;
                end else begin
                  state_r <= ST_FILL_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FILL_RD: state_r <= ST_FILL_WR;
        ST_FILL_WR: begin
          left_r  <= fill_val;
          diag_r  <= up_val;
          state_r <= ST_FILL_RD;
          if (j_r == len_b_r) begin
            j_r    <= LEN_W'(1);
            left_r <= '0;
            if (i_r == len_a_r) begin
              i_r     <= len_a_r;
              j_r     <= len_b_r;
              state_r <= ST_TR_HERE;
            end else begin
              i_r <= i_r + LEN_W'(1);
            end
          end else begin
            j_r <= j_r + LEN_W'(1);
          end
        end
        ST_TR_HERE: state_r <= ST_TR_UP;
        ST_TR_UP: begin
          here_r <= sc_rdata;
          // corner cell is the length
          if (i_r == len_a_r && j_r == len_b_r) len_r <= sc_rdata;
          state_r <= ST_TR_LEFT;
        end
        ST_TR_LEFT: begin
          up_r    <= (i_r == LEN_W'(1)) ? '0 : sc_rdata;
          state_r <= ST_TR_DEC;
        end
        ST_TR_DEC: begin
          i_r <= ni;
          j_r <= nj;
          n_r <= n_next;
          if (ni == '0 || nj == '0) begin
            if (n_next == '0) begin
              out_valid_r  <= 1'b1;
              char_valid_r <= 1'b0;
              last_r       <= 1'b1;
              state_r      <= ST_EMIT_OUT;
            end else begin
              state_r <= ST_EMIT_RD;
            end
          end else begin
            state_r <= ST_TR_HERE;
          end
        end
        ST_EMIT_RD: begin
          out_valid_r  <= 1'b1;
          char_valid_r <= 1'b1;
          last_r       <= (k_r == n_r - LEN_W'(1));
          state_r      <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (last_r) begin
              len_a_r    <= '0;
              len_b_r    <= '0;
              overflow_r <= 1'b0;
              state_r    <= ST_IDLE;
            end else begin
              k_r     <= k_r + LEN_W'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_lcs_length = LEN_W'(len_r);
  assign out_sub_char   = char_valid_r ? tb_rdata : '0;
  assign out_char_valid = char_valid_r;
  assign out_truncated  = overflow_r;
  assign out_last       = last_r;

endmodule

### design/lcs_byte_ram.sv
// ---------------------------------------------------------------------------
// lcs_byte_ram
// Byte store of MAX_LEN entries, one write and one registered read a cycle.
// ---------------------------------------------------------------------------
module lcs_byte_ram (
  input  logic                         clk,
  input  lcs_pkg::byte_req_t           req,
  output logic [lcs_pkg::SYM_W-1:0]    rdata
);
  import lcs_pkg::*;

  logic [SYM_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### design/lcs_score_ram.sv
// ---------------------------------------------------------------------------
// lcs_score_ram
// Score table, (MAX_LEN+1) squared cells, one write and one registered read.
// ---------------------------------------------------------------------------
module lcs_score_ram (
  input  logic                          clk,
  input  lcs_pkg::score_req_t           req,
  output logic [lcs_pkg::SCORE_W-1:0]   rdata
);
  import lcs_pkg::*;

  logic [SCORE_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### tb/lcs_length_and_traceback_tb.sv
// ---------------------------------------------------------------------------
// lcs_length_and_traceback_tb
// Loads byte strings into both sides of the LCS block, fires runs and checks
// every result beat against a software LCS fill and traceback or a typed beat,
// in step with the accepted input beats. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module lcs_length_and_traceback_tb;
  import lcs_pkg::*;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam int RANDOM_BEATS = 240;
  localparam int MAX_CYCLES   = 1000000;
  localparam int N_DIRECTED   = 28;

  typedef struct packed {
    logic [LEN_W-1:0] score_len;
    logic [SYM_W-1:0] symbol;
    logic             sym_valid;
    logic             trunc;
    logic             last;
  } lcs_beat_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [SYM_W-1:0] symbol;
    logic [7:0]       reps;
    logic             typed;
    lcs_beat_t        want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func = FUNC_LOAD_A;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LEN_W-1:0]    out_lcs_length;
  logic [SYM_W-1:0]    out_sub_char;
  logic                out_char_valid;
  logic                out_truncated;
  logic                out_last;

  // predictor state
  logic [SYM_W-1:0]    str_a [MAX_LEN];
  logic [SYM_W-1:0]    str_b [MAX_LEN];
  logic [SCORE_W-1:0]  lcs_score [DIM][DIM];
  logic [SYM_W-1:0]    found_syms [MAX_LEN];
  int                  count_a = 0;
  int                  count_b = 0;
  logic                dropped_load = 1'b0;

  lcs_beat_t           pending_beats [$];
  lcs_beat_t           head_beat;
  directed_row_t       directed_rows [N_DIRECTED];
  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  counted_beats = 0;
  int                  hold_cycles = 0;
  logic                quiet_phase;

  lcs_length_and_traceback dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lcs_length (out_lcs_length),
    .out_sub_char   (out_sub_char),
    .out_char_valid (out_char_valid),
    .out_truncated  (out_truncated),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stretches with no idling on either side
  assign quiet_phase = (cycle_count % 3000) < 700;

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int gap_length();
    if (quiet_phase || $urandom_range(0, 99) < 65) return 0;
    return idle_length();
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 96) return $urandom_range(9, 24);
    return MAX_LEN;
  endfunction

  task automatic predict_run(input logic typed, input lcs_beat_t typed_beat);
    int i, j, n;
    logic [SCORE_W-1:0] best;
    lcs_beat_t beat;
    for (i = 0; i <= count_a; i++) lcs_score[i][0] = '0;
    for (j = 0; j <= count_b; j++) lcs_score[0][j] = '0;
    for (i = 1; i <= count_a; i++) begin
      for (j = 1; j <= count_b; j++) begin
        if (str_a[i-1] == str_b[j-1]) lcs_score[i][j] = lcs_score[i-1][j-1] + 7'd1;
        else if (lcs_score[i-1][j] > lcs_score[i][j-1]) lcs_score[i][j] = lcs_score[i-1][j];
        else lcs_score[i][j] = lcs_score[i][j-1];
      end
    end
    best = lcs_score[count_a][count_b];
    // walk back from the corner: up first, then left, else take the diagonal
    n = 0;
    i = count_a;
    j = count_b;
    while (i > 0 && j > 0) begin
      if (lcs_score[i][j] == lcs_score[i-1][j]) i--;
      else if (lcs_score[i][j] == lcs_score[i][j-1]) j--;
      else begin
        found_syms[n] = str_a[i-1];
        n++;
        i--;
        j--;
      end
    end
    if (typed) pending_beats.push_back(typed_beat);
    else if (n == 0) begin
      beat = '{score_len: '0, symbol: '0, sym_valid: 1'b0, trunc: dropped_load, last: 1'b1};
      pending_beats.push_back(beat);
    end else begin
      for (i = n - 1; i >= 0; i--) begin
        beat = '{score_len: best, symbol: found_syms[i], sym_valid: 1'b1,
                 trunc: dropped_load, last: (i == 0)};
        pending_beats.push_back(beat);
      end
    end
    count_a = 0;
    count_b = 0;
    dropped_load = 1'b0;
  endtask

  task automatic apply_beat(input logic [1:0] func, input logic [SYM_W-1:0] sym,
                            input logic typed, input lcs_beat_t typed_beat);
    case (func)
      FUNC_LOAD_A: begin
        if (count_a < MAX_LEN) begin
          str_a[count_a] = sym;
          count_a++;
        end else dropped_load = 1'b1;
      end
      FUNC_LOAD_B: begin
        if (count_b < MAX_LEN) begin
          str_b[count_b] = sym;
          count_b++;
        end else dropped_load = 1'b1;
      end
      FUNC_RUN: predict_run(typed, typed_beat);
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input logic [1:0] func, input logic [SYM_W-1:0] sym,
                           input logic typed, input lcs_beat_t typed_beat);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(func, sym, typed, typed_beat);
    if (func != FUNC_IGNORED) counted_beats++;
  endtask

  task automatic send_sequence();
    int kind, na, nb, extra, alpha, base;
    logic to_a;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) send_beat(FUNC_IGNORED, 8'($urandom()), 1'b0, '0);
    end else if (kind < 18) begin
      // loose load and run beats, runs at odd points included
      repeat ($urandom_range(1, 4))
        send_beat(2'($urandom_range(0, 2)), 8'($urandom()), 1'b0, '0);
    end else begin
      na = pick_length();
      nb = pick_length();
      extra = ((na == MAX_LEN || nb == MAX_LEN) && $urandom_range(0, 1)) ?
              $urandom_range(1, 3) : 0;
      kind = $urandom_range(0, 99);
      alpha = (kind < 40) ? 2 : (kind < 75) ? 4 : (kind < 90) ? 16 : 256;
      base = $urandom_range(0, 256 - alpha);
      while (na > 0 || nb > 0) begin
        to_a = (nb == 0) || (na > 0 && $urandom_range(0, 1));
        send_beat(to_a ? FUNC_LOAD_A : FUNC_LOAD_B,
                  8'(base + $urandom_range(0, alpha - 1)), 1'b0, '0);
        if (to_a) na--;
        else nb--;
      end
      repeat (extra)
        send_beat(count_a >= MAX_LEN ? FUNC_LOAD_A : FUNC_LOAD_B, 8'($urandom()), 1'b0, '0);
      send_beat(FUNC_RUN, 8'($urandom()), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual len %0d char %0h last %0b",
                 $time, out_lcs_length, out_sub_char, out_last);
        error_count++;
      end else begin
        head_beat = pending_beats.pop_front();
        check_field("lcs_length", 8'(head_beat.score_len), 8'(out_lcs_length));
        check_field("sub_char", head_beat.symbol, out_sub_char);
        check_field("char_valid", 8'(head_beat.sym_valid), 8'(out_char_valid));
        check_field("truncated", 8'(head_beat.trunc), 8'(out_truncated));
        check_field("last", 8'(head_beat.last), 8'(out_last));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 99) < 30) begin
      hold_cycles <= idle_length() - 1;
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
      $display("lcs_length_and_traceback verification failed");
      $finish;
    end
  end

  initial begin
    // typed rows: only where the answer is obvious
    directed_rows = '{
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
      '{FUNC_IGNORED, 8'hFF, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'hFF, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
      '{FUNC_LOAD_A,  8'h00, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_B,  8'h00, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd1, 8'h00, 1'b1, 1'b0, 1'b1}},
      '{FUNC_LOAD_B,  8'hFF, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_A,  8'hFF, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd1, 8'hFF, 1'b1, 1'b0, 1'b1}},
      '{FUNC_LOAD_A,  8'h41, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
      '{FUNC_LOAD_B,  8'h5A, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
      '{FUNC_LOAD_A,  8'h11, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_B,  8'h22, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
      // crossed order: tie-break of the traceback decides the symbols
      '{FUNC_LOAD_A,  8'h41, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_A,  8'h42, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_B,  8'h42, 8'd1,  1'b0, '0},
      '{FUNC_LOAD_B,  8'h41, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b0, '0},
      // string A past capacity, one dropped byte
      '{FUNC_LOAD_A,  8'hAA, 8'd65, 1'b0, '0},
      '{FUNC_LOAD_B,  8'hAA, 8'd1,  1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd1, 8'hAA, 1'b1, 1'b1, 1'b1}},
      // both full, full-length subsequence, overflow on B
      '{FUNC_LOAD_A,  8'h55, 8'd64, 1'b0, '0},
      '{FUNC_LOAD_B,  8'h55, 8'd65, 1'b0, '0},
      '{FUNC_RUN,     8'h00, 8'd1,  1'b0, '0},
      // overflow flag must not leak into the next run
      '{FUNC_RUN,     8'h00, 8'd1,  1'b1, '{7'd0, 8'h00, 1'b0, 1'b0, 1'b1}}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[r])
      repeat (directed_rows[r].reps)
        send_beat(directed_rows[r].func, directed_rows[r].symbol,
                  directed_rows[r].typed, directed_rows[r].want);
    counted_beats = 0;
    while (counted_beats < RANDOM_BEATS) send_sequence();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("lcs_length_and_traceback verification clean");
    end else begin
      $display("lcs_length_and_traceback verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/lcs_pkg.sv
design/lcs_byte_ram.sv
design/lcs_score_ram.sv
design/lcs_length_and_traceback.sv
tb/lcs_length_and_traceback_tb.sv
